>>> rtl/hcbd_pkg.sv
// Shared types, codes and helpers for the chunked body decoder.
package hcbd_pkg;

  // Width of the saturating payload counter
  localparam int unsigned LENGTH_BITS = 24;
  // Width of the decoded length reported on the result word
  localparam int unsigned LEN_OUT_W   = 24;
  localparam int unsigned SIZE_W      = 32;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Digit value meaning "not a hex digit"
  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_SIZE_CR  = 3'd1,
    PH_DATA     = 3'd2,
    PH_TRAIL    = 3'd3,
    PH_TRAIL_CR = 3'd4,
    PH_DONE     = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ZERO_CHUNK = 2'd0,
    KIND_IN_SIZE    = 2'd1,
    KIND_TRUNCATED  = 2'd2,
    KIND_ZERO_BYTE  = 2'd3
  } end_kind_e;

  // Outcome of one size-line byte
  typedef struct packed {
    phase_e              phase;
    logic                hex_done;
    logic [SIZE_W-1:0]   chunk;
    logic                load;   // chunk size goes to the data countdown
    logic                stop;   // decoding ends here
    end_kind_e           kind;
  } size_res_t;

  // Digit value of an ASCII hex character, HEX_NONE otherwise
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] d;
    d = HEX_NONE;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = 5'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = 5'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = 5'(b - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  // One byte of a size line
  function automatic size_res_t size_step(phase_e ph, logic hd,
                                          logic [SIZE_W-1:0] cv, logic [7:0] b);
    size_res_t  r;
    logic [4:0] d;
    d          = hex_digit(b);
    r.phase    = ph;
    r.hex_done = hd;
    r.chunk    = cv;
    r.load     = 1'b0;
    r.stop     = 1'b0;
    r.kind     = KIND_ZERO_CHUNK;
    if (b == CH_NUL) begin
      r.phase = PH_DONE;
      r.stop  = 1'b1;
      r.kind  = KIND_ZERO_BYTE;
    end else if (ph == PH_SIZE_CR && b == CH_LF) begin
      if (cv == '0) begin
        r.phase = PH_DONE;
        r.stop  = 1'b1;
        r.kind  = KIND_ZERO_CHUNK;
      end else begin
        r.load  = 1'b1;
        r.phase = PH_DATA;
      end
    end else begin
      if (!hd) begin
        if (d != HEX_NONE) begin
          r.chunk = {cv[SIZE_W-5:0], (d[3:0] & 4'hF)};
        end else begin
          r.hex_done = 1'b1;
        end
      end
      r.phase = (b == CH_CR) ? PH_SIZE_CR : PH_SIZE;
    end
    return r;
  endfunction

endpackage

>>> rtl/http_chunked_body_decoder_unit.sv
// Chunked body decoder: one input word per cycle unless stalled, one result word at most.
// A result word is registered in the output register, or in the skid stage on output stall.
// Throughput: one input word every cycle unless stalled; the decode state update is a single
// registered step (compare, shift or decrement), backed by an output register and skid stage.
// Reset: asynchronous, active low; clears decode state and the valids of both result stages.
module http_chunked_body_decoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           last_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           byte_valid_o,
  output logic [7:0]                     out_byte_o,
  output logic                           body_end_o,
  output logic [hcbd_pkg::LEN_OUT_W-1:0] decoded_length_o,
  output logic [1:0]                     end_kind_o
);
  import hcbd_pkg::*;

  typedef struct packed {
    logic                 byte_valid;
    logic [7:0]           data;
    logic                 body_end;
    logic [LEN_OUT_W-1:0] length;
    logic [1:0]           kind;
  } result_t;

  // Decode state
  phase_e                 phase_q, phase_n, phase_d;
  logic                   hex_done_q, hex_done_n, hex_done_d;
  logic [SIZE_W-1:0]      chunk_q, chunk_n, chunk_d;
  logic [SIZE_W-1:0]      left_q, left_n, left_d;
  logic [LENGTH_BITS-1:0] count_q, count_n, count_d;
  end_kind_e              stop_kind_q, stop_kind_n, stop_kind_d;

  // Result stages
  result_t res, out_q, skid_q;
  logic    res_valid, pass_byte;
  logic    out_valid_q, skid_valid_q;
  logic    accept, out_take, out_free;

  size_res_t sz_cur, sz_line, sz_cr, sz_sel;
  logic      use_sz;

  assign accept   = in_valid_i & ~skid_valid_q;
  assign out_take = out_valid_q & ~out_stall_i;
  assign out_free = ~out_valid_q | out_take;

  // Size-line candidates: current line, fresh line, line opened by a held CR
  assign sz_cur  = size_step(phase_q, hex_done_q, chunk_q, in_byte_i);
  assign sz_line = size_step(PH_SIZE, 1'b0, '0, in_byte_i);
  assign sz_cr   = size_step(PH_SIZE_CR, 1'b1, '0, in_byte_i);

  // Next state for one word
  always_comb begin
    phase_n     = phase_q;
    hex_done_n  = hex_done_q;
    chunk_n     = chunk_q;
    left_n      = left_q;
    count_n     = count_q;
    stop_kind_n = stop_kind_q;
    pass_byte   = 1'b0;
    use_sz      = 1'b0;
    sz_sel      = sz_cur;
    unique case (phase_q)
      PH_SIZE, PH_SIZE_CR: begin
        use_sz = 1'b1;
      end
      PH_DATA: begin
        pass_byte = 1'b1;
        if (count_q != LEN_MAX) begin
          count_n = count_q + 1'b1;
        end
        left_n = left_q - 1'b1;
        if (left_q == SIZE_W'(1)) begin
          phase_n = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (in_byte_i == CH_LF) begin
          phase_n    = PH_SIZE;
          hex_done_n = 1'b0;
          chunk_n    = '0;
        end else if (in_byte_i == CH_CR) begin
          phase_n = PH_TRAIL_CR;
        end else begin
          use_sz = 1'b1;
          sz_sel = sz_line;
        end
      end
      PH_TRAIL_CR: begin
        if (in_byte_i == CH_LF) begin
          phase_n    = PH_SIZE;
          hex_done_n = 1'b0;
          chunk_n    = '0;
        end else begin
          // held CR opens the next size line
          use_sz = 1'b1;
          sz_sel = sz_cr;
        end
      end
      default: ;  // stopped, and codes with no meaning
    endcase
    if (use_sz) begin
      phase_n    = sz_sel.phase;
      hex_done_n = sz_sel.hex_done;
      chunk_n    = sz_sel.chunk;
      if (sz_sel.load) begin
        left_n = sz_sel.chunk;
      end
      if (sz_sel.stop) begin
        stop_kind_n = sz_sel.kind;
      end
    end
  end

  // End of body returns the decode state to its reset values
  always_comb begin
    if (last_byte_i) begin
      phase_d     = PH_SIZE;
      hex_done_d  = 1'b0;
      chunk_d     = '0;
      left_d      = '0;
      count_d     = '0;
      stop_kind_d = KIND_ZERO_CHUNK;
    end else begin
      phase_d     = phase_n;
      hex_done_d  = hex_done_n;
      chunk_d     = chunk_n;
      left_d      = left_n;
      count_d     = count_n;
      stop_kind_d = stop_kind_n;
    end
  end

  // Result word
  always_comb begin
    res_valid      = pass_byte | last_byte_i;
    res.byte_valid = pass_byte;
    res.data       = pass_byte ? in_byte_i : 8'h00;
    res.body_end   = last_byte_i;
    res.length     = LEN_OUT_W'(count_n);
    res.kind       = KIND_ZERO_CHUNK;
    if (last_byte_i) begin
      unique case (phase_n)
        PH_DATA:                                    res.kind = KIND_TRUNCATED;
        PH_SIZE, PH_SIZE_CR, PH_TRAIL, PH_TRAIL_CR: res.kind = KIND_IN_SIZE;
        default:                                    res.kind = stop_kind_n;
      endcase
    end
  end

  // Decode state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      hex_done_q  <= 1'b0;
      chunk_q     <= '0;
      left_q      <= '0;
      count_q     <= '0;
      stop_kind_q <= KIND_ZERO_CHUNK;
    end else if (accept) begin
      phase_q     <= phase_d;
      hex_done_q  <= hex_done_d;
      chunk_q     <= chunk_d;
      left_q      <= left_d;
      count_q     <= count_d;
      stop_kind_q <= stop_kind_d;
    end
  end

  // Output register and skid stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept & res_valid;
      end
    end else if (accept & res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payloads
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept & res_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign byte_valid_o     = out_q.byte_valid;
  assign out_byte_o       = out_q.data;
  assign body_end_o       = out_q.body_end;
  assign decoded_length_o = out_q.length;
  assign end_kind_o       = out_q.kind;

endmodule
